@@ sv/prefix_varint_stream_decoder_unit_assert.svh @@
// Assertion macros used by the decoder's top-level RTL file.
`ifndef PREFIX_VARINT_STREAM_DECODER_UNIT_ASSERT_SVH
`define PREFIX_VARINT_STREAM_DECODER_UNIT_ASSERT_SVH

// Checks that the condition holds in the same cycle as the trigger.
`define PVD_ASSERT_NOW(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Checks that the condition holds in the cycle after the trigger.
`define PVD_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ sv/pvd_pkg.sv @@
// Types, codes and constants of the prefix varint stream decoder.
package pvd_pkg;

    typedef enum logic [2:0] {
        KIND_SHORT,
        KIND_U32,
        KIND_U64,
        KIND_ZZ64,
        KIND_FIX1,
        KIND_FIX2,
        KIND_FIX4,
        KIND_FIX8
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_BAD_HDR,
        STAT_TRUNC
    } t_status;

    localparam logic [7:0] C_HDR_ONE  = 8'h80;
    localparam logic [7:0] C_HDR_TWO  = 8'hc0;
    localparam logic [7:0] C_HDR_FULL = 8'hff;
    localparam logic [7:0] C_LOW6     = 8'h3f;
    localparam logic [7:0] C_LOW7     = 8'h7f;
    localparam logic [3:0] C_U32_MAX  = 4'd3;
    localparam logic [3:0] C_U32_NEED = 4'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [2:0] req_type;
        logic       end_of_data;
    } t_in_item;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
        logic [2:0]  kind_done;
    } t_out_item;

    typedef struct packed {
        logic        busy;
        logic [2:0]  kind;
        logic [3:0]  bytes_left;
        logic [2:0]  fixed_shift;
        logic [63:0] acc;
    } t_state;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

endpackage

@@ sv/pvd_if.sv @@
// Handshake channels of the decoder: byte input and decoded value output.
interface pvd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [2:0] req_type;
    logic       end_of_data;

    modport source (output valid, output data_byte, output req_type, output end_of_data,
                    input ready);
    modport sink (input valid, input data_byte, input req_type, input end_of_data,
                  output ready);
endinterface

interface pvd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [1:0]  status;
    logic [2:0]  kind_done;

    modport source (output valid, output value, output status, output kind_done,
                    input ready);
    modport sink (input valid, input value, input status, input kind_done,
                  output ready);
endinterface

@@ sv/pvd_step.sv @@
// Next-state and result logic for one input byte of the decoder.
module pvd_step (
    input  pvd_pkg::t_state   i_state,
    input  pvd_pkg::t_in_item i_item,
    output pvd_pkg::t_state   o_state_n,
    output pvd_pkg::t_result  o_res
);

    function automatic logic [3:0] f_lead_ones(input logic [7:0] b);
        logic [3:0] n;
        logic       run;
        n   = 4'd0;
        run = 1'b1;
        for (int i = 7; i >= 0; i--) begin
            if (run && b[i]) begin
                n = n + 4'd1;
            end else begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

    function automatic logic [63:0] f_finish(input logic [2:0] kind, input logic [63:0] acc);
        logic [63:0] v;
        if (kind == pvd_pkg::KIND_SHORT) begin
            v = {{48{acc[15]}}, acc[15:0]};
        end else if (kind == pvd_pkg::KIND_ZZ64) begin
            v = (acc >> 1) ^ {64{acc[0]}};
        end else begin
            v = acc;
        end
        return v;
    endfunction

    always_comb begin
        pvd_pkg::t_kind rt;
        logic [7:0]     b;
        logic [3:0]     lead;
        logic [3:0]     need;
        logic [63:0]    acc;
        logic           bad;
        logic [3:0]     left;

        b    = i_item.data_byte;
        rt   = pvd_pkg::t_kind'(i_item.req_type);
        lead = f_lead_ones(b);
        need = 4'd0;
        acc  = 64'd0;
        bad  = 1'b0;
        left = i_state.bytes_left - 4'd1;

        o_state_n            = i_state;
        o_res.valid          = 1'b0;
        o_res.item.value     = 64'd0;
        o_res.item.status    = pvd_pkg::STAT_OK;
        o_res.item.kind_done = i_state.kind;

        if (!i_state.busy) begin
            o_state_n.kind        = i_item.req_type;
            o_state_n.fixed_shift = 3'd0;
            o_res.item.kind_done  = i_item.req_type;
            unique case (rt)
                pvd_pkg::KIND_SHORT: begin
                    if (b < pvd_pkg::C_HDR_ONE) begin
                        acc = {56'd0, b};
                    end else if (b < pvd_pkg::C_HDR_TWO) begin
                        acc  = {56'd0, b & pvd_pkg::C_LOW6};
                        need = 4'd1;
                    end else if (b == pvd_pkg::C_HDR_FULL) begin
                        need = 4'd2;
                    end else begin
                        bad = 1'b1;
                    end
                end
                pvd_pkg::KIND_U32: begin
                    if (lead <= pvd_pkg::C_U32_MAX) begin
                        need = lead;
                        acc  = {56'd0, b & (pvd_pkg::C_LOW7 >> lead)};
                    end else begin
                        need = pvd_pkg::C_U32_NEED;
                    end
                end
                pvd_pkg::KIND_U64, pvd_pkg::KIND_ZZ64: begin
                    need = lead;
                    acc  = {56'd0, b & (pvd_pkg::C_LOW7 >> lead)};
                end
                default: begin
                    acc                   = {56'd0, b};
                    o_state_n.fixed_shift = 3'd1;
                    need                  = (4'd1 << i_item.req_type[1:0]) - 4'd1;
                end
            endcase

            if (bad || need == 4'd0 || i_item.end_of_data) begin
                o_res.valid = 1'b1;
                priority if (bad) begin
                    o_res.item.status = pvd_pkg::STAT_BAD_HDR;
                end else if (need == 4'd0) begin
                    o_res.item.value = f_finish(i_item.req_type, acc);
                end else begin
                    o_res.item.status = pvd_pkg::STAT_TRUNC;
                end
                o_state_n.busy        = 1'b0;
                o_state_n.bytes_left  = 4'd0;
                o_state_n.fixed_shift = 3'd0;
                o_state_n.acc         = 64'd0;
            end else begin
                o_state_n.busy       = 1'b1;
                o_state_n.bytes_left = need;
                o_state_n.acc        = acc;
            end
        end else begin
            if (i_state.kind[2]) begin
                acc = i_state.acc | ({56'd0, b} << {i_state.fixed_shift, 3'b000});
                o_state_n.fixed_shift = i_state.fixed_shift + 3'd1;
            end else begin
                acc = {i_state.acc[55:0], b};
            end
            o_state_n.bytes_left = left;
            o_state_n.acc        = acc;

            if (left == 4'd0 || i_item.end_of_data) begin
                o_res.valid = 1'b1;
                if (left == 4'd0) begin
                    o_res.item.value = f_finish(i_state.kind, acc);
                end else begin
                    o_res.item.status = pvd_pkg::STAT_TRUNC;
                end
                o_state_n.busy        = 1'b0;
                o_state_n.bytes_left  = 4'd0;
                o_state_n.fixed_shift = 3'd0;
                o_state_n.acc         = 64'd0;
            end
        end
    end

endmodule

@@ sv/prefix_varint_stream_decoder_unit.sv @@
// Top level of the prefix varint stream decoder.
//
// Channel  | Direction | Payload                               | Transfer
// i_in     | in        | data_byte[8] req_type[3] end_of_data[1] | valid && ready
// o_out    | out       | value[64] status[2] kind_done[3]      | valid && ready
//
// One byte is taken per cycle unless a result waits on a stalled output.
// A result passes through the input register, then through the byte step
// logic into the result register.
// Reset clears the decode state and both valid flags.
// A stalled output holds its result; bytes that complete nothing keep moving,
// and the next result-producing byte waits in the input register.
`include "prefix_varint_stream_decoder_unit_assert.svh"

module prefix_varint_stream_decoder_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pvd_in_if.sink           i_in,
    pvd_out_if.source        o_out
);

    logic               r_s1_valid;
    pvd_pkg::t_in_item  r_s1_item;
    pvd_pkg::t_state    r_state;
    pvd_pkg::t_state    n_state;
    pvd_pkg::t_result   w_res;
    logic               r_out_valid;
    pvd_pkg::t_out_item r_out_item;
    logic               w_out_free;
    logic               w_consume;

    pvd_step u_step (
        .i_state   (r_state),
        .i_item    (r_s1_item),
        .o_state_n (n_state),
        .o_res     (w_res)
    );

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_consume  = r_s1_valid && (!w_res.valid || w_out_free);
    assign i_in.ready = !r_s1_valid || w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (w_consume) begin
                r_state <= n_state;
            end
            if (w_consume && w_res.valid) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_item.data_byte   <= i_in.data_byte;
            r_s1_item.req_type    <= i_in.req_type;
            r_s1_item.end_of_data <= i_in.end_of_data;
        end
        if (w_consume && w_res.valid) begin
            r_out_item <= w_res.item;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.value     = r_out_item.value;
    assign o_out.status    = r_out_item.status;
    assign o_out.kind_done = r_out_item.kind_done;

    `PVD_ASSERT_NEXT(a_idle_after_result, i_clk, i_rst_n, w_consume && w_res.valid, !r_state.busy, "decoder still busy after a result")
    `PVD_ASSERT_NOW(a_busy_has_bytes, i_clk, i_rst_n, r_state.busy, r_state.bytes_left != 4'd0, "busy with no bytes left")
    `PVD_ASSERT_NOW(a_error_value_zero, i_clk, i_rst_n, r_out_valid && r_out_item.status != pvd_pkg::STAT_OK, r_out_item.value == 64'd0, "error result with nonzero value")
    `PVD_ASSERT_NOW(a_fixed_shift_set, i_clk, i_rst_n, r_state.busy && r_state.kind[2], r_state.fixed_shift != 3'd0, "fixed read busy with zero byte index")

endmodule
